@@ src/ebga_pkg.sv @@
package ebga_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int ADDR_W     = $clog2(NODE_COUNT);

  // one store row: {sticky saturation, z, y, x}
  localparam int COMP_W  = 64;
  localparam int ROW_W   = 3 * COMP_W + 1;
  localparam int SAT_BIT = 3 * COMP_W;

  // shared divider: 80-bit dividend (Q32.32 magnitude shifted by 16), 32-bit divisor
  localparam int DIV_W   = 80;
  localparam int DEN_W   = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_INTERIOR = 3'd1;
  localparam logic [2:0] OP_BEDGE    = 3'd2;
  localparam logic [2:0] OP_BFACE    = 3'd3;
  localparam logic [2:0] OP_FINALIZE = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_VOL = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic [1:0] DIM_3D = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic [9:0]         node_a;
    logic [9:0]         node_b;
    logic [9:0]         node_c;
    logic signed [31:0] pressure_a;
    logic signed [31:0] pressure_b;
    logic signed [31:0] pressure_c;
    logic signed [31:0] coef_x;
    logic signed [31:0] coef_y;
    logic signed [31:0] coef_z;
    logic [31:0]        volume;
  } in_req_t;

  typedef struct packed {
    logic [9:0]         node_out;
    logic signed [63:0] grad_x;
    logic signed [63:0] grad_y;
    logic signed [63:0] grad_z;
    logic [1:0]         status;
  } out_req_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  function automatic logic [ADDR_W-1:0] node_addr(input logic [9:0] n);
    logic [31:0] r;
    r = 32'(n) % NODE_COUNT;
    return r[ADDR_W-1:0];
  endfunction

endpackage

@@ src/ebga_ram.sv @@
module ebga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/ebga_div.sv @@
module ebga_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ebga_pkg::DIV_W-1:0]    dividend,
  input  logic [ebga_pkg::DEN_W-1:0]    divisor,
  output logic                          busy,
  output logic                          done,
  output logic [ebga_pkg::DIV_W-1:0]    quotient
);

  logic                             busy_r;
  logic                             done_r;
  logic [ebga_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [ebga_pkg::DEN_W-1:0]       rem_r;
  logic [ebga_pkg::DEN_W-1:0]       den_r;
  logic [ebga_pkg::DIV_W-1:0]       quo_r;
  logic [ebga_pkg::DEN_W:0]         rem_sh;
  logic                             fits;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[ebga_pkg::DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        den_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= fits ? rem_sh[ebga_pkg::DEN_W-1:0] - den_r : rem_sh[ebga_pkg::DEN_W-1:0];
        quo_r <= {quo_r[ebga_pkg::DIV_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ebga_pkg::DIV_CNT_W'(ebga_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ src/edge_based_gradient_accumulator_unit.sv @@
// edge-based green-gauss gradient accumulator
// input channel in_valid / in_stall carries one request (in_data): clear, interior
// edge, boundary edge, boundary face, finalize or read. a request is taken when
// in_valid is high and in_stall low; in_stall stays high while a request is in work.
// result channel out_valid / out_stall carries one result for finalize and read
// only; the output register lets the block take the next request while a result
// is still waiting.
// cfg_valid / cfg_ready writes mesh_dimension (3 = x,y,z, anything else = x,y);
// write it only while the block is idle.
// gradients live in one single-port 1024 x 193 bit memory (three Q32.32 comps
// plus a sticky saturation bit), each update is read, modify, write back.
// work per request: clear writes a zero row; interior edge and boundary face
// go through weight, multiply, read and add/write for each node; boundary edge
// adds a reciprocal divide-by-three step per node; read fetches the row;
// finalize fetches it, runs the bit-serial volume divide per touched component
// and writes it back, or only keeps each sign when the volume is zero.
// reset (synchronous, rst_n low) clears control state and sets mesh_dimension
// to 3; the memory is not cleared, every node must be cleared before use.
// a result still stalled when the next one is ready holds the block in its
// output state until it is taken.
module edge_based_gradient_accumulator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ebga_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ebga_pkg::out_req_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WGT  = 4'd1;   // form weight for node k
  localparam logic [3:0] S_WDIV = 4'd2;   // divide by three, reciprocal multiply
  localparam logic [3:0] S_MUL  = 4'd3;   // weight times coefficients
  localparam logic [3:0] S_RD   = 4'd4;   // issue row read
  localparam logic [3:0] S_ADD  = 4'd5;   // saturating add, write back
  localparam logic [3:0] S_CLR  = 4'd6;
  localparam logic [3:0] S_FRD  = 4'd7;   // finalize / read: issue read
  localparam logic [3:0] S_FLD  = 4'd8;   // latch row
  localparam logic [3:0] S_FDIV = 4'd9;   // per component volume divide
  localparam logic [3:0] S_FDW  = 4'd10;
  localparam logic [3:0] S_FWR  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam logic signed [63:0] MAX64 = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] MIN64 = {1'b1, {63{1'b0}}};

  // ceil(2^34 / 3), exact for dividends below 2^33
  localparam logic [32:0] RECIP3 = 33'h1_5555_5556;

  logic [3:0]                 state_r, state_nxt;
  ebga_pkg::in_req_t          req_r;
  logic [1:0]                 dim_r;
  logic [1:0]                 k_r;        // node slot a, b, c
  logic [1:0]                 comp_r;     // component in finalize
  logic signed [33:0]         w_r;
  logic                       wneg_r;
  logic signed [63:0]         prod_r [3];
  logic [ebga_pkg::ROW_W-1:0] data_r;
  logic                       fsat_r;
  logic                       out_valid_r;
  ebga_pkg::out_req_t         out_data_r;

  logic                       dim3;
  logic [1:0]                 last_k;
  logic [1:0]                 last_comp;

  assign dim3      = (dim_r == ebga_pkg::DIM_3D);
  assign last_k    = (req_r.operation == ebga_pkg::OP_BFACE) ? 2'd2 : 2'd1;
  assign last_comp = dim3 ? 2'd2 : 2'd1;

  // ---------------------------------------------------------------- weights
  logic signed [36:0] pa, pb, pc, own, oth1, oth2;
  logic signed [36:0] sum_int, x_edge, y_edge, x_face;
  logic signed [36:0] w_comb;
  logic               edge_neg;
  logic [36:0]        edge_mag;
  logic [65:0]        edge_prod;
  logic [33:0]        edge_q;

  assign pa = 37'(req_r.pressure_a);
  assign pb = 37'(req_r.pressure_b);
  assign pc = 37'(req_r.pressure_c);

  always_comb begin
    unique case (k_r)
      2'd0:    begin own = pa; oth1 = pb; oth2 = pc; end
      2'd1:    begin own = pb; oth1 = pa; oth2 = pc; end
      default: begin own = pc; oth1 = pa; oth2 = pb; end
    endcase
  end

  // interior: floor of half the sum, node b takes the negative
  assign sum_int = (pa + pb) >>> 1;
  // boundary edge: floor(x/6) = floor(floor(x/2)/3)
  assign x_edge  = (own <<< 2) + own + oth1;
  assign y_edge  = x_edge >>> 1;
  assign edge_neg = y_edge[36];
  // floor of a negative quotient: -((|y| + 2) / 3)
  assign edge_mag = edge_neg ? 37'(37'sd2 - y_edge) : y_edge;
  // boundary face: (6 own + others) / 8, floored
  assign x_face  = ((own <<< 2) + (own <<< 1) + oth1 + oth2) >>> 3;

  // magnitude held in w_r, divided by three
  assign edge_prod = {33'b0, w_r[32:0]} * {33'b0, RECIP3};
  assign edge_q    = {2'b0, edge_prod[65:34]};

  always_comb begin
    unique case (req_r.operation)
      ebga_pkg::OP_INTERIOR: w_comb = (k_r == 2'd0) ? sum_int : -sum_int;
      default:               w_comb = x_face;
    endcase
  end

  // ---------------------------------------------------------------- divider
  logic                            div_start;
  logic                            div_busy;
  logic                            div_done;
  logic [ebga_pkg::DIV_W-1:0]      div_dvd;
  logic [ebga_pkg::DEN_W-1:0]      div_den;
  logic [ebga_pkg::DIV_W-1:0]      div_q;
  logic [63:0]                     comp_val;
  logic                            comp_neg;
  logic [63:0]                     comp_mag;

  assign comp_val = data_r[{comp_r, 6'b0} +: 64];
  assign comp_neg = comp_val[63];
  assign comp_mag = comp_neg ? 64'(-comp_val) : comp_val;

  assign div_start = (state_r == S_FDIV) && (comp_r <= last_comp) && (req_r.volume != '0);
  assign div_dvd   = {comp_mag, 16'b0};
  assign div_den   = req_r.volume;

  ebga_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // quotient back to signed Q32.32 with saturation
  logic signed [63:0] fin_val;
  logic               fin_sat;

  always_comb begin
    fin_sat = 1'b0;
    if (comp_neg) begin
      if (div_q[79:64] != '0 || (div_q[63] && div_q[62:0] != '0)) begin
        fin_sat = 1'b1;
        fin_val = MIN64;
      end else begin
        fin_val = -$signed(div_q[63:0]);
      end
    end else begin
      if (div_q[79:63] != '0) begin
        fin_sat = 1'b1;
        fin_val = MAX64;
      end else begin
        fin_val = $signed(div_q[63:0]);
      end
    end
  end

  // zero volume: keep the sign only
  logic signed [63:0] zero_val;
  assign zero_val = comp_neg ? MIN64 : ((comp_val != '0) ? MAX64 : 64'sd0);

  // ---------------------------------------------------------------- memory
  logic [ebga_pkg::ADDR_W-1:0] ram_addr;
  logic                        ram_we;
  logic [ebga_pkg::ROW_W-1:0]  ram_wdata;
  logic [ebga_pkg::ROW_W-1:0]  ram_rdata;
  logic [ebga_pkg::ROW_W-1:0]  add_row;
  logic [9:0]                  node_k;

  always_comb begin
    unique case (k_r)
      2'd0:    node_k = req_r.node_a;
      2'd1:    node_k = req_r.node_b;
      default: node_k = req_r.node_c;
    endcase
  end

  // saturating accumulate of the products (z only in 3d) onto the row just read
  always_comb begin
    logic signed [64:0] s;
    logic signed [63:0] g;
    logic               any_sat;
    any_sat = 1'b0;
    add_row = ram_rdata;
    for (int i = 0; i < 3; i++) begin
      g = ram_rdata[i*64 +: 64];
      s = {g[63], g} + {prod_r[i][63], prod_r[i]};
      if (i < 2 || dim3) begin
        if (s[64] != s[63]) begin
          any_sat = 1'b1;
          add_row[i*64 +: 64] = s[64] ? MIN64 : MAX64;
        end else begin
          add_row[i*64 +: 64] = s[63:0];
        end
      end
    end
    add_row[ebga_pkg::SAT_BIT] = ram_rdata[ebga_pkg::SAT_BIT] | any_sat;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = ebga_pkg::node_addr(req_r.node_a);
    ram_wdata = data_r;
    unique case (state_r)
      S_RD:    ram_addr = ebga_pkg::node_addr(node_k);
      S_ADD: begin
        ram_addr  = ebga_pkg::node_addr(node_k);
        ram_we    = 1'b1;
        ram_wdata = add_row;
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_FWR:   ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  ebga_ram #(
    .WIDTH (ebga_pkg::ROW_W),
    .DEPTH (ebga_pkg::NODE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- control
  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority case (in_data.operation)
            ebga_pkg::OP_CLEAR:    state_nxt = S_CLR;
            ebga_pkg::OP_INTERIOR,
            ebga_pkg::OP_BEDGE,
            ebga_pkg::OP_BFACE:    state_nxt = S_WGT;
            ebga_pkg::OP_FINALIZE,
            ebga_pkg::OP_READ:     state_nxt = S_FRD;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      S_WGT:  state_nxt = (req_r.operation == ebga_pkg::OP_BEDGE) ? S_WDIV : S_MUL;
      S_WDIV: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_RD;
      S_RD:   state_nxt = S_ADD;
      S_ADD:  state_nxt = (k_r == last_k) ? S_IDLE : S_WGT;
      S_CLR:  state_nxt = S_IDLE;
      S_FRD:  state_nxt = S_FLD;
      S_FLD:  state_nxt = (req_r.operation == ebga_pkg::OP_FINALIZE) ? S_FDIV : S_OUT;
      S_FDIV: begin
        if (comp_r > last_comp) begin
          state_nxt = S_FWR;
        end else if (req_r.volume != '0) begin
          state_nxt = S_FDW;
        end
      end
      S_FDW:  state_nxt = div_done ? S_FDIV : S_FDW;
      S_FWR:  state_nxt = S_OUT;
      S_OUT:  state_nxt = out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [1:0] status_comb;
  always_comb begin
    if (req_r.operation == ebga_pkg::OP_FINALIZE && req_r.volume == '0) begin
      status_comb = ebga_pkg::ST_ZERO_VOL;
    end else if (data_r[ebga_pkg::SAT_BIT] ||
                 (req_r.operation == ebga_pkg::OP_FINALIZE && fsat_r)) begin
      status_comb = ebga_pkg::ST_SAT;
    end else begin
      status_comb = ebga_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_r       <= ebga_pkg::DIM_3D;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      comp_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        dim_r <= cfg_data;
      end
      // load a new result or drop the one just taken
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          req_r <= in_data;
          k_r   <= '0;
        end
        S_WGT: begin
          w_r    <= (req_r.operation == ebga_pkg::OP_BEDGE) ? 34'(edge_mag) : 34'(w_comb);
          wneg_r <= edge_neg;
        end
        S_WDIV: begin
          w_r <= wneg_r ? -$signed(edge_q) : $signed(edge_q);
        end
        S_MUL: begin
          prod_r[0] <= 64'(w_r * req_r.coef_x);
          prod_r[1] <= 64'(w_r * req_r.coef_y);
          prod_r[2] <= 64'(w_r * req_r.coef_z);
        end
        S_ADD: k_r <= k_r + 1'b1;
        S_FLD: begin
          data_r <= ram_rdata;
          comp_r <= '0;
          fsat_r <= 1'b0;
        end
        S_FDIV: begin
          if (comp_r <= last_comp && req_r.volume == '0) begin
            data_r[{comp_r, 6'b0} +: 64] <= zero_val;
            comp_r <= comp_r + 1'b1;
          end
        end
        S_FDW: begin
          if (div_done) begin
            data_r[{comp_r, 6'b0} +: 64] <= fin_val;
            fsat_r <= fsat_r | fin_sat;
            comp_r <= comp_r + 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r.node_out <= req_r.node_a;
            out_data_r.grad_x   <= data_r[63:0];
            out_data_r.grad_y   <= data_r[127:64];
            out_data_r.grad_z   <= data_r[191:128];
            out_data_r.status   <= status_comb;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // divider only runs inside the volume divide wait
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_FDW))
    else $error("divider busy outside a divide state");

  // memory writes only from write states
  a_ram_we: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_ADD || state_r == S_CLR || state_r == S_FWR))
    else $error("memory write in wrong state");

  // a new result only follows the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside output state");

  // every write back is preceded by its read
  a_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |-> $past(state_r) == S_RD)
    else $error("write back without read");

endmodule
